@@ src/ipas_pkg.sv @@
// Package for the indirect parameter access sequencer.
// Holds the beat structs, request/result codes and register indexes; no dependencies.
`timescale 1ns / 1ps

package ipas_pkg;

  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_ADDR_REG      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DATA_LOW_REG  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DATA_HIGH_REG = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_ACTION_REG    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_READ_CODE     = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_WRITE_CODE    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_WAIT_TICKS    = 3'd6;

  localparam logic [3:0] REQ_START_RD    = 4'd0;
  localparam logic [3:0] REQ_START_WR    = 4'd1;
  localparam logic [3:0] REQ_LINK_OPEN   = 4'd2;
  localparam logic [3:0] REQ_WRITE_ACK   = 4'd3;
  localparam logic [3:0] REQ_READ_DATA   = 4'd4;
  localparam logic [3:0] REQ_ERR_LINK    = 4'd5;
  localparam logic [3:0] REQ_ERR_WR_PROT = 4'd6;
  localparam logic [3:0] REQ_ERR_WR_TRAN = 4'd7;
  localparam logic [3:0] REQ_ERR_RD_PROT = 4'd8;
  localparam logic [3:0] REQ_ERR_RD_TRAN = 4'd9;
  localparam logic [3:0] REQ_TICK        = 4'd10;

  localparam logic [1:0] KIND_OPEN  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;
  localparam logic [1:0] KIND_DONE  = 2'd3;

  localparam logic [2:0] CAUSE_NONE    = 3'd0;
  localparam logic [2:0] CAUSE_LINK    = 3'd1;
  localparam logic [2:0] CAUSE_WR_PROT = 3'd2;
  localparam logic [2:0] CAUSE_WR_TRAN = 3'd3;
  localparam logic [2:0] CAUSE_RD_PROT = 3'd4;
  localparam logic [2:0] CAUSE_RD_TRAN = 3'd5;

  localparam logic [1:0] QTY_ONE = 2'd1;
  localparam logic [1:0] QTY_TWO = 2'd2;

  typedef struct packed {
    logic [3:0]  req_type;
    logic [7:0]  slave_id;
    logic [15:0] param_addr;
    logic [15:0] word_low;
    logic [15:0] word_high;
    logic        is_32bit;
    logic [1:0]  read_count;
    logic [15:0] read_word0;
    logic [15:0] read_word1;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  target_id;
    logic [15:0] reg_addr;
    logic [15:0] reg_value;
    logic [1:0]  read_qty;
    logic        op_is_write;
    logic        success;
    logic [2:0]  error_cause;
    logic [15:0] result_low;
    logic [15:0] result_high;
  } out_item_t;

endpackage

@@ src/indirect_param_access_sequencer.sv @@
// Top level of the indirect parameter access sequencer.
// Depends on ipas_pkg for beat structs and codes.
`timescale 1ns / 1ps

// Takes one input beat every cycle unless in_stall is high; each beat updates
// the sequencer state in a single pass and its result (if any) is registered
// for the out_ channel. Results sit in an output register backed by one skid
// entry, so in_stall rises only once two results are waiting downstream.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only be changed while no operation is in flight.
module indirect_param_access_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  ipas_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output ipas_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [ipas_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [15:0]                      cfg_wdata
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ADDR, PH_DATA1, PH_DATA2, PH_ACTION, PH_WAITING, PH_READ
  } phase_t;

  phase_t phase_r, phase_nxt;
  logic        write_op_r, write_op_nxt;
  logic [7:0]  held_target_r, held_target_nxt;
  logic [15:0] held_param_r, held_param_nxt;
  logic [15:0] held_low_r, held_low_nxt;
  logic [15:0] held_high_r, held_high_nxt;
  logic        held_wide_r, held_wide_nxt;
  logic        timer_running_r, timer_running_nxt;
  logic [15:0] timer_left_r, timer_left_nxt;

  logic [15:0] addr_reg_r, data_low_reg_r, data_high_reg_r, action_reg_r;
  logic [15:0] read_code_r, write_code_r, wait_ticks_r;

  logic                out_valid_r, out_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  ipas_pkg::out_item_t out_data_r, out_data_nxt;
  ipas_pkg::out_item_t skid_data_r, skid_data_nxt;

  logic                in_fire, out_fire, do_step, res_valid;
  ipas_pkg::out_item_t res;

  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid & ~skid_valid_r;
  assign out_fire  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_reg_r      <= 16'd100;
      data_low_reg_r  <= 16'd101;
      data_high_reg_r <= 16'd102;
      action_reg_r    <= 16'd103;
      read_code_r     <= 16'd1;
      write_code_r    <= 16'd3;
      wait_ticks_r    <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        ipas_pkg::CFG_ADDR_REG:      addr_reg_r      <= cfg_wdata;
        ipas_pkg::CFG_DATA_LOW_REG:  data_low_reg_r  <= cfg_wdata;
        ipas_pkg::CFG_DATA_HIGH_REG: data_high_reg_r <= cfg_wdata;
        ipas_pkg::CFG_ACTION_REG:    action_reg_r    <= cfg_wdata;
        ipas_pkg::CFG_READ_CODE:     read_code_r     <= cfg_wdata;
        ipas_pkg::CFG_WRITE_CODE:    write_code_r    <= cfg_wdata;
        ipas_pkg::CFG_WAIT_TICKS:    wait_ticks_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer next state and result
  always_comb begin
    phase_nxt         = phase_r;
    write_op_nxt      = write_op_r;
    held_target_nxt   = held_target_r;
    held_param_nxt    = held_param_r;
    held_low_nxt      = held_low_r;
    held_high_nxt     = held_high_r;
    held_wide_nxt     = held_wide_r;
    timer_running_nxt = timer_running_r;
    timer_left_nxt    = timer_left_r;
    res               = '0;
    res_valid         = 1'b0;
    do_step           = 1'b0;

    if (in_fire) begin
      case (in_data.req_type)
        ipas_pkg::REQ_START_RD, ipas_pkg::REQ_START_WR: begin
          if (phase_r == PH_IDLE) begin
            write_op_nxt    = (in_data.req_type == ipas_pkg::REQ_START_WR);
            held_target_nxt = in_data.slave_id;
            held_param_nxt  = in_data.param_addr;
            held_low_nxt    = write_op_nxt ? in_data.word_low : 16'd0;
            held_high_nxt   = write_op_nxt ? in_data.word_high : 16'd0;
            held_wide_nxt   = in_data.is_32bit;
            phase_nxt       = PH_ADDR;
            res_valid       = 1'b1;
            res.kind        = ipas_pkg::KIND_OPEN;
            res.target_id   = in_data.slave_id;
          end
        end
        ipas_pkg::REQ_LINK_OPEN: do_step = (phase_r == PH_ADDR);
        ipas_pkg::REQ_WRITE_ACK: do_step = 1'b1;
        ipas_pkg::REQ_READ_DATA: begin
          if (phase_r == PH_READ) begin
            res_valid         = 1'b1;
            res.kind          = ipas_pkg::KIND_DONE;
            res.target_id     = held_target_r;
            res.success       = 1'b1;
            res.error_cause   = ipas_pkg::CAUSE_NONE;
            res.result_low    = (in_data.read_count != 2'd0) ? in_data.read_word0 : 16'd0;
            res.result_high   = in_data.read_count[1] ? in_data.read_word1 : 16'd0;
            phase_nxt         = PH_IDLE;
            timer_running_nxt = 1'b0;
            timer_left_nxt    = 16'd0;
          end
        end
        ipas_pkg::REQ_ERR_LINK, ipas_pkg::REQ_ERR_WR_PROT, ipas_pkg::REQ_ERR_WR_TRAN,
        ipas_pkg::REQ_ERR_RD_PROT, ipas_pkg::REQ_ERR_RD_TRAN: begin
          if (phase_r != PH_IDLE) begin
            res_valid         = 1'b1;
            res.kind          = ipas_pkg::KIND_DONE;
            res.target_id     = held_target_r;
            res.error_cause   = 3'(in_data.req_type - ipas_pkg::REQ_READ_DATA);
            phase_nxt         = PH_IDLE;
            timer_running_nxt = 1'b0;
            timer_left_nxt    = 16'd0;
          end
        end
        ipas_pkg::REQ_TICK: begin
          if (timer_running_r) begin
            if (timer_left_r > 16'd1) begin
              timer_left_nxt = timer_left_r - 16'd1;
            end else begin
              timer_running_nxt = 1'b0;
              timer_left_nxt    = 16'd0;
              phase_nxt         = PH_READ;
              res_valid         = 1'b1;
              res.kind          = ipas_pkg::KIND_READ;
              res.target_id     = held_target_r;
              res.reg_addr      = data_low_reg_r;
              res.read_qty      = held_wide_r ? ipas_pkg::QTY_TWO : ipas_pkg::QTY_ONE;
            end
          end
        end
        default: ;
      endcase
    end

    if (do_step) begin
      res.target_id = held_target_r;
      res.kind      = ipas_pkg::KIND_WRITE;
      case (phase_r)
        PH_ADDR: begin
          res_valid     = 1'b1;
          res.reg_addr  = addr_reg_r;
          res.reg_value = held_param_r;
          phase_nxt     = write_op_r ? PH_DATA1 : PH_ACTION;
        end
        PH_DATA1: begin
          res_valid     = 1'b1;
          res.reg_addr  = data_low_reg_r;
          res.reg_value = held_low_r;
          phase_nxt     = held_wide_r ? PH_DATA2 : PH_ACTION;
        end
        PH_DATA2: begin
          res_valid     = 1'b1;
          res.reg_addr  = data_high_reg_r;
          res.reg_value = held_high_r;
          phase_nxt     = PH_ACTION;
        end
        PH_ACTION: begin
          res_valid     = 1'b1;
          res.reg_addr  = action_reg_r;
          res.reg_value = write_op_r ? write_code_r : read_code_r;
          phase_nxt     = PH_WAITING;
        end
        PH_WAITING: begin
          timer_running_nxt = 1'b1;
          timer_left_nxt    = (wait_ticks_r != 16'd0) ? wait_ticks_r : 16'd1;
        end
        default: ;
      endcase
    end

    res.op_is_write = write_op_nxt;
  end

  // output register plus one skid entry
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (!out_valid_r || out_fire) begin
      out_valid_nxt = res_valid;
      out_data_nxt  = res;
    end else if (res_valid) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_IDLE;
      write_op_r      <= 1'b0;
      held_target_r   <= 8'd0;
      held_param_r    <= 16'd0;
      held_low_r      <= 16'd0;
      held_high_r     <= 16'd0;
      held_wide_r     <= 1'b0;
      timer_running_r <= 1'b0;
      timer_left_r    <= 16'd0;
      out_valid_r     <= 1'b0;
      skid_valid_r    <= 1'b0;
    end else begin
      phase_r         <= phase_nxt;
      write_op_r      <= write_op_nxt;
      held_target_r   <= held_target_nxt;
      held_param_r    <= held_param_nxt;
      held_low_r      <= held_low_nxt;
      held_high_r     <= held_high_nxt;
      held_wide_r     <= held_wide_nxt;
      timer_running_r <= timer_running_nxt;
      timer_left_r    <= timer_left_nxt;
      out_valid_r     <= out_valid_nxt;
      skid_valid_r    <= skid_valid_nxt;
    end
    out_data_r    <= out_data_nxt;
    skid_data_r   <= skid_data_nxt;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with output register empty");

  a_timer_phase: assert property (@(posedge clk) disable iff (!rst_n)
    timer_running_r |-> (phase_r == PH_WAITING && timer_left_r != 16'd0))
    else $error("timer running outside wait phase or at zero");

  a_fail_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.kind == ipas_pkg::KIND_DONE && !out_data_r.success)
      |-> (out_data_r.result_low == 16'd0 && out_data_r.result_high == 16'd0
           && out_data_r.error_cause != ipas_pkg::CAUSE_NONE))
    else $error("failed done beat carries data or no cause");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && res_valid && res.kind == ipas_pkg::KIND_DONE) |=> (phase_r == PH_IDLE))
    else $error("done beat did not return sequencer to idle");

endmodule

@@ sim/ipas_seq_checker.sv @@
// Scoreboard for the indirect parameter access sequencer: tracks register writes,
// predicts each result beat from accepted input beats and compares on the out_ side.
// Depends on ipas_pkg for beat structs, request/result codes and register indexes.
`timescale 1ns / 1ps

module ipas_seq_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  ipas_pkg::in_item_t             in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  ipas_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [ipas_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [15:0]                    cfg_wdata,
  output int unsigned                    mismatches,
  output int unsigned                    outstanding
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADDR, ST_DATA_LO, ST_DATA_HI, ST_ACTION, ST_WAIT, ST_READBACK
  } seq_state_t;

  logic [15:0] reg_addr_no, reg_lo_no, reg_hi_no, reg_act_no;
  logic [15:0] code_rd, code_wr, wait_cfg;

  seq_state_t  seq_state;
  logic        op_write;
  logic [7:0]  hold_tgt;
  logic [15:0] hold_param, hold_lo, hold_hi;
  logic        hold_wide;
  logic        tick_on;
  logic [15:0] ticks_left;

  ipas_pkg::out_item_t want_q[$];

  function automatic ipas_pkg::out_item_t make_beat(logic [1:0] kind, logic [15:0] regno,
                                                    logic [15:0] val, logic [1:0] qty);
    ipas_pkg::out_item_t r;
    r = '0;
    r.kind        = kind;
    r.target_id   = hold_tgt;
    r.reg_addr    = regno;
    r.reg_value   = val;
    r.read_qty    = qty;
    r.op_is_write = op_write;
    return r;
  endfunction

  task automatic close_op(input logic ok, input logic [2:0] cause,
                          input logic [15:0] lo, input logic [15:0] hi);
    ipas_pkg::out_item_t r;
    r = make_beat(ipas_pkg::KIND_DONE, '0, '0, '0);
    r.success     = ok;
    r.error_cause = cause;
    r.result_low  = lo;
    r.result_high = hi;
    want_q.push_back(r);
    seq_state  = ST_IDLE;
    tick_on    = 1'b0;
    ticks_left = '0;
  endtask

  task automatic issue_next_write();
    case (seq_state)
      ST_ADDR: begin
        want_q.push_back(make_beat(ipas_pkg::KIND_WRITE, reg_addr_no, hold_param, '0));
        seq_state = op_write ? ST_DATA_LO : ST_ACTION;
      end
      ST_DATA_LO: begin
        want_q.push_back(make_beat(ipas_pkg::KIND_WRITE, reg_lo_no, hold_lo, '0));
        seq_state = hold_wide ? ST_DATA_HI : ST_ACTION;
      end
      ST_DATA_HI: begin
        want_q.push_back(make_beat(ipas_pkg::KIND_WRITE, reg_hi_no, hold_hi, '0));
        seq_state = ST_ACTION;
      end
      ST_ACTION: begin
        want_q.push_back(make_beat(ipas_pkg::KIND_WRITE, reg_act_no,
                                   op_write ? code_wr : code_rd, '0));
        seq_state = ST_WAIT;
      end
      ST_WAIT: begin
        tick_on    = 1'b1;
        ticks_left = (wait_cfg == '0) ? 16'd1 : wait_cfg;
      end
      default: ;
    endcase
  endtask

  task automatic predict_beat(input ipas_pkg::in_item_t b);
    logic [2:0] cause;
    case (b.req_type)
      ipas_pkg::REQ_START_RD, ipas_pkg::REQ_START_WR: begin
        if (seq_state == ST_IDLE) begin
          op_write   = (b.req_type == ipas_pkg::REQ_START_WR);
          hold_tgt   = b.slave_id;
          hold_param = b.param_addr;
          hold_lo    = op_write ? b.word_low : '0;
          hold_hi    = op_write ? b.word_high : '0;
          hold_wide  = b.is_32bit;
          seq_state  = ST_ADDR;
          want_q.push_back(make_beat(ipas_pkg::KIND_OPEN, '0, '0, '0));
        end
      end
      ipas_pkg::REQ_LINK_OPEN: begin
        if (seq_state == ST_ADDR) issue_next_write();
      end
      ipas_pkg::REQ_WRITE_ACK: issue_next_write();
      ipas_pkg::REQ_READ_DATA: begin
        if (seq_state == ST_READBACK) begin
          close_op(1'b1, ipas_pkg::CAUSE_NONE, (b.read_count >= 2'd1) ? b.read_word0 : '0,
                   (b.read_count >= 2'd2) ? b.read_word1 : '0);
        end
      end
      ipas_pkg::REQ_ERR_LINK, ipas_pkg::REQ_ERR_WR_PROT, ipas_pkg::REQ_ERR_WR_TRAN,
      ipas_pkg::REQ_ERR_RD_PROT, ipas_pkg::REQ_ERR_RD_TRAN: begin
        case (b.req_type)
          ipas_pkg::REQ_ERR_LINK:    cause = ipas_pkg::CAUSE_LINK;
          ipas_pkg::REQ_ERR_WR_PROT: cause = ipas_pkg::CAUSE_WR_PROT;
          ipas_pkg::REQ_ERR_WR_TRAN: cause = ipas_pkg::CAUSE_WR_TRAN;
          ipas_pkg::REQ_ERR_RD_PROT: cause = ipas_pkg::CAUSE_RD_PROT;
          default:                   cause = ipas_pkg::CAUSE_RD_TRAN;
        endcase
        if (seq_state != ST_IDLE) close_op(1'b0, cause, '0, '0);
      end
      ipas_pkg::REQ_TICK: begin
        if (tick_on) begin
          if (ticks_left > 16'd1) begin
            ticks_left = ticks_left - 16'd1;
          end else begin
            tick_on    = 1'b0;
            ticks_left = '0;
            seq_state  = ST_READBACK;
            want_q.push_back(make_beat(ipas_pkg::KIND_READ, reg_lo_no, '0,
                                       hold_wide ? ipas_pkg::QTY_TWO : ipas_pkg::QTY_ONE));
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    ipas_pkg::out_item_t w;
    if (!rst_n) begin
      reg_addr_no = 16'd100;
      reg_lo_no   = 16'd101;
      reg_hi_no   = 16'd102;
      reg_act_no  = 16'd103;
      code_rd     = 16'd1;
      code_wr     = 16'd3;
      wait_cfg    = 16'd200;
      seq_state   = ST_IDLE;
      op_write    = 1'b0;
      hold_tgt    = '0;
      hold_param  = '0;
      hold_lo     = '0;
      hold_hi     = '0;
      hold_wide   = 1'b0;
      tick_on     = 1'b0;
      ticks_left  = '0;
      mismatches  = 0;
      want_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (want_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, actual %h", $time, out_data);
        end else begin
          w = want_q.pop_front();
          check_field("kind", 16'(w.kind), 16'(out_data.kind));
          check_field("target_id", 16'(w.target_id), 16'(out_data.target_id));
          check_field("reg_addr", w.reg_addr, out_data.reg_addr);
          check_field("reg_value", w.reg_value, out_data.reg_value);
          check_field("read_qty", 16'(w.read_qty), 16'(out_data.read_qty));
          check_field("op_is_write", 16'(w.op_is_write), 16'(out_data.op_is_write));
          check_field("success", 16'(w.success), 16'(out_data.success));
          check_field("error_cause", 16'(w.error_cause), 16'(out_data.error_cause));
          check_field("result_low", w.result_low, out_data.result_low);
          check_field("result_high", w.result_high, out_data.result_high);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ipas_pkg::CFG_ADDR_REG:      reg_addr_no = cfg_wdata;
          ipas_pkg::CFG_DATA_LOW_REG:  reg_lo_no   = cfg_wdata;
          ipas_pkg::CFG_DATA_HIGH_REG: reg_hi_no   = cfg_wdata;
          ipas_pkg::CFG_ACTION_REG:    reg_act_no  = cfg_wdata;
          ipas_pkg::CFG_READ_CODE:     code_rd     = cfg_wdata;
          ipas_pkg::CFG_WRITE_CODE:    code_wr     = cfg_wdata;
          ipas_pkg::CFG_WAIT_TICKS:    wait_cfg    = cfg_wdata;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict_beat(in_data);
    end
    outstanding = want_q.size();
  end

endmodule

@@ sim/indirect_param_access_sequencer_tb.sv @@
// Testbench top for the indirect parameter access sequencer: clock, reset, register
// setup, directed and random beat streams with idle/stall phases, and the verdict.
// Depends on ipas_pkg, the sequencer RTL and ipas_seq_checker.
`timescale 1ns / 1ps

module indirect_param_access_sequencer_tb;

  localparam logic [3:0] REQ_UNUSED_LO = 4'd11;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
  localparam int unsigned PHASE_BEATS = 200;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  ipas_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  ipas_pkg::out_item_t           out_data;
  logic                          cfg_we;
  logic [ipas_pkg::CfgIdxW-1:0]  cfg_index;
  logic [15:0]                   cfg_wdata;
  int unsigned                   mismatches;
  int unsigned                   outstanding;

  int unsigned         idle_pct;
  int unsigned         stall_pct;
  int unsigned         beats_sent;
  int unsigned         wait_setting;

  indirect_param_access_sequencer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  ipas_seq_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic ipas_pkg::in_item_t rand_beat();
    ipas_pkg::in_item_t b;
    b.req_type   = 4'($urandom_range(15));
    b.slave_id   = 8'($urandom_range(255));
    b.param_addr = 16'($urandom_range(65535));
    b.word_low   = 16'($urandom_range(65535));
    b.word_high  = 16'($urandom_range(65535));
    b.is_32bit   = 1'($urandom_range(1));
    b.read_count = 2'($urandom_range(3));
    b.read_word0 = 16'($urandom_range(65535));
    b.read_word1 = 16'($urandom_range(65535));
    return b;
  endfunction

  function automatic logic [3:0] rand_err();
    return 4'(ipas_pkg::REQ_ERR_LINK + $urandom_range(4));
  endfunction

  task automatic send_beat(input ipas_pkg::in_item_t b);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= b;
    beats_sent++;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_req(input logic [3:0] req);
    ipas_pkg::in_item_t b;
    b = rand_beat();
    b.req_type = req;
    send_beat(b);
  endtask

  // hold off the sender until every predicted result beat is out
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic quiesce();
    send_req(rand_err());
    settle();
  endtask

  task automatic write_reg(input logic [ipas_pkg::CfgIdxW-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] a_no, lo_no, hi_no, act_no,
                           input logic [15:0] rd_code, wr_code, wt);
    write_reg(ipas_pkg::CFG_ADDR_REG, a_no);
    write_reg(ipas_pkg::CFG_DATA_LOW_REG, lo_no);
    write_reg(ipas_pkg::CFG_DATA_HIGH_REG, hi_no);
    write_reg(ipas_pkg::CFG_ACTION_REG, act_no);
    write_reg(ipas_pkg::CFG_READ_CODE, rd_code);
    write_reg(ipas_pkg::CFG_WRITE_CODE, wr_code);
    write_reg(ipas_pkg::CFG_WAIT_TICKS, wt);
    wait_setting = 32'(wt);
  endtask

  task automatic load_random_regs(input logic [15:0] wt);
    load_regs(16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)),
              16'($urandom_range(65535)), 16'($urandom_range(65535)), wt);
  endtask

  task automatic maybe_noise(input bit noisy);
    if (noisy && $urandom_range(99) < 30) send_beat(rand_beat());
  endtask

  // one access from start to done; noisy ones get stray beats and a cleanup error
  task automatic run_op(input int unsigned noise_pct);
    ipas_pkg::in_item_t b;
    int unsigned acks;
    int unsigned ticks;
    bit          noisy;
    noisy = ($urandom_range(99) < noise_pct);
    if ($urandom_range(99) < 3) settle();
    b = rand_beat();
    b.req_type = $urandom_range(1) ? ipas_pkg::REQ_START_WR : ipas_pkg::REQ_START_RD;
    acks  = 2 + ((b.req_type == ipas_pkg::REQ_START_WR) ? 1 + b.is_32bit : 0);
    ticks = (wait_setting == 0) ? 1 : wait_setting;
    send_beat(b);
    maybe_noise(noisy);
    send_req(($urandom_range(99) < 80) ? ipas_pkg::REQ_LINK_OPEN : ipas_pkg::REQ_WRITE_ACK);
    repeat (acks) begin
      maybe_noise(noisy);
      send_req(ipas_pkg::REQ_WRITE_ACK);
    end
    maybe_noise(noisy);
    repeat (ticks + $urandom_range(1)) send_req(ipas_pkg::REQ_TICK);
    if ($urandom_range(99) < noise_pct / 2) send_req(rand_err());
    else send_req(ipas_pkg::REQ_READ_DATA);
    if (noisy) send_req(rand_err());
  endtask

  task automatic run_phase(input int unsigned sender_pct, input int unsigned receiver_pct);
    int unsigned mark;
    idle_pct  = sender_pct;
    stall_pct = receiver_pct;
    mark = beats_sent;
    while (beats_sent - mark < PHASE_BEATS) run_op(25);
    quiesce();
  endtask

  initial begin
    ipas_pkg::in_item_t b;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    rst_n        = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    beats_sent   = 0;
    wait_setting = 200;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset register values
    run_op(0);
    run_op(0);
    quiesce();

    // directed: stray and out-of-phase beats, ticks of zero act as one, every error cause
    load_regs(16'h0010, 16'h0011, 16'h0012, 16'h0013, 16'h0021, 16'h0023, 16'd0);
    send_req(ipas_pkg::REQ_ERR_LINK);
    send_req(ipas_pkg::REQ_TICK);
    send_req(ipas_pkg::REQ_WRITE_ACK);
    send_req(ipas_pkg::REQ_READ_DATA);
    send_req(ipas_pkg::REQ_LINK_OPEN);
    send_req(REQ_UNUSED_LO);
    send_req(REQ_UNUSED_HI);
    b = rand_beat();
    b.req_type   = ipas_pkg::REQ_START_RD;
    b.slave_id   = '1;
    b.param_addr = '1;
    b.word_low   = '1;
    b.word_high  = '1;
    b.is_32bit   = 1'b1;
    send_beat(b);
    send_req(ipas_pkg::REQ_START_WR);
    repeat (3) send_req(ipas_pkg::REQ_WRITE_ACK);
    send_req(ipas_pkg::REQ_TICK);
    b = rand_beat();
    b.req_type   = ipas_pkg::REQ_READ_DATA;
    b.read_count = 2'd3;
    b.read_word0 = '1;
    b.read_word1 = '1;
    send_beat(b);
    b = '0;
    b.req_type = ipas_pkg::REQ_START_WR;
    b.is_32bit = 1'b1;
    send_beat(b);
    repeat (2) send_req(ipas_pkg::REQ_LINK_OPEN);
    repeat (5) send_req(ipas_pkg::REQ_WRITE_ACK);
    send_req(ipas_pkg::REQ_TICK);
    b = rand_beat();
    b.req_type   = ipas_pkg::REQ_READ_DATA;
    b.read_count = '0;
    send_beat(b);
    for (int k = 0; k < 5; k++) begin
      send_req(k[0] ? ipas_pkg::REQ_START_WR : ipas_pkg::REQ_START_RD);
      send_req(ipas_pkg::REQ_LINK_OPEN);
      send_req(4'(ipas_pkg::REQ_ERR_LINK + k));
    end
    quiesce();

    load_random_regs(16'd2);
    run_phase(0, 0);
    load_regs('0, '0, '0, '0, '0, '0, '0);
    run_phase(82, 0);
    load_regs('1, '1, '1, '1, '1, '1, 16'd3);
    run_phase(0, 82);
    load_random_regs(16'($urandom_range(1, 5)));
    run_phase(12, 12);

    // full-width timer, cut short by an error
    load_random_regs(16'hFFFF);
    idle_pct  = 0;
    stall_pct = 0;
    b = rand_beat();
    b.req_type = ipas_pkg::REQ_START_WR;
    b.is_32bit = 1'b1;
    send_beat(b);
    send_req(ipas_pkg::REQ_LINK_OPEN);
    repeat (4) send_req(ipas_pkg::REQ_WRITE_ACK);
    repeat (6) send_req(ipas_pkg::REQ_TICK);
    send_req(ipas_pkg::REQ_ERR_RD_TRAN);
    settle();

    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
